@@ rtl/mrve_pkg.sv @@
// Package for the matrix row/vector engine: sizes, operation and register
// codes, controller state and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrve_pkg;

	// Matrix geometry and element format
	localparam int MAX_ROWS  = 256;
	localparam int MAX_COLS  = 128;
	localparam int ELEM_BITS = 16;
	localparam int ROW_W     = 8;
	localparam int COL_W     = 7;
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int ACC_W     = 40;
	localparam int PROD_W    = 2 * ELEM_BITS;
	localparam int FRAC_BITS = 12;

	// Configuration register widths and indexes
	localparam int ROWS_CFG_W = 9;
	localparam int COLS_CFG_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

	// Result kinds
	localparam logic KIND_DOT = 1'b0;
	localparam logic KIND_VEC = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE      = 2'd0,
		OP_DOT        = 2'd1,
		OP_ADD_TO_ROW = 2'd2,
		OP_ADD_TO_VEC = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_MUL  = 2'd2,
		S_DONE = 2'd3
	} state_t;

	// Command from controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted request
		logic rd_en;   // read the addressed element
		logic mul_en;  // register the product
		logic finish;  // write back / accumulate / emit
		logic last;    // request is at the last column in use
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/mrve_ctrl.sv @@
// Controller of the matrix row/vector engine: configuration registers,
// address range check and the per-request sequencer. Depends on mrve_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrve_ctrl (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire [mrve_pkg::ROW_W-1:0]            row_index,
	input  wire [mrve_pkg::COL_W-1:0]            col_index,
	input  wire                                  cfg_valid,
	input  wire [mrve_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [mrve_pkg::ROWS_CFG_W-1:0]       cfg_data,
	output logic                                 cfg_ready,
	output logic                                 busy,
	output mrve_pkg::cmd_t                       cmd
);

	mrve_pkg::state_t state_q, state_d;
	logic [mrve_pkg::ROWS_CFG_W-1:0] rows_q;
	logic [mrve_pkg::COLS_CFG_W-1:0] cols_q;
	logic [mrve_pkg::ROWS_CFG_W-1:0] eff_rows;
	logic [mrve_pkg::COLS_CFG_W-1:0] eff_cols;
	logic in_range;
	logic is_last;
	logic accept;
	logic last_q;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mrve_pkg::ROWS_CFG_W'(mrve_pkg::MAX_ROWS);
			cols_q <= mrve_pkg::COLS_CFG_W'(mrve_pkg::MAX_COLS);
		end else if (cfg_valid) begin
			case (cfg_index)
				mrve_pkg::CFG_ROWS_IN_USE: rows_q <= cfg_data;
				mrve_pkg::CFG_COLS_IN_USE: cols_q <= cfg_data[mrve_pkg::COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp registers into 1..MAX
	always_comb begin
		if (rows_q == '0)
			eff_rows = mrve_pkg::ROWS_CFG_W'(1);
		else if (rows_q > mrve_pkg::ROWS_CFG_W'(mrve_pkg::MAX_ROWS))
			eff_rows = mrve_pkg::ROWS_CFG_W'(mrve_pkg::MAX_ROWS);
		else
			eff_rows = rows_q;
		if (cols_q == '0)
			eff_cols = mrve_pkg::COLS_CFG_W'(1);
		else if (cols_q > mrve_pkg::COLS_CFG_W'(mrve_pkg::MAX_COLS))
			eff_cols = mrve_pkg::COLS_CFG_W'(mrve_pkg::MAX_COLS);
		else
			eff_cols = cols_q;
	end

	// Out-of-use addresses are dropped at acceptance
	assign in_range = ({1'b0, row_index} < eff_rows) && ({1'b0, col_index} < eff_cols);
	assign is_last  = ({1'b0, col_index} == (eff_cols - mrve_pkg::COLS_CFG_W'(1)));
	assign busy     = (state_q != mrve_pkg::S_IDLE);
	assign accept   = start && !busy && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrve_pkg::S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				last_q <= is_last;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrve_pkg::S_IDLE: if (accept) state_d = mrve_pkg::S_READ;
			mrve_pkg::S_READ: state_d = mrve_pkg::S_MUL;
			mrve_pkg::S_MUL:  state_d = mrve_pkg::S_DONE;
			mrve_pkg::S_DONE: state_d = mrve_pkg::S_IDLE;
			default:          state_d = mrve_pkg::S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd      = '0;
		cmd.last = last_q;
		case (state_q)
			mrve_pkg::S_IDLE: cmd.load   = accept;
			mrve_pkg::S_READ: cmd.rd_en  = 1'b1;
			mrve_pkg::S_MUL:  cmd.mul_en = 1'b1;
			mrve_pkg::S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_load_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == mrve_pkg::S_READ)
		else $error("load not followed by read");
	a_read_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> cmd.mul_en)
		else $error("read not followed by multiply");
	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy && !$past(cmd.load))
		else $error("controller still busy after finish");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(state_q) != mrve_pkg::S_MUL)
		else $error("request taken while sequencing");
`endif

endmodule
`default_nettype wire

@@ rtl/mrve_dp.sv @@
// Datapath of the matrix row/vector engine: matrix memory, multiplier,
// accumulator, saturation and result registers. Depends on mrve_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrve_dp (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  mrve_pkg::cmd_t                              cmd,
	input  wire [1:0]                                   operation,
	input  wire [mrve_pkg::ROW_W-1:0]                   row_index,
	input  wire [mrve_pkg::COL_W-1:0]                   col_index,
	input  wire signed [mrve_pkg::ELEM_BITS-1:0]        element_value,
	input  wire signed [mrve_pkg::ELEM_BITS-1:0]        scale,
	output logic                                        result_valid,
	output logic                                        result_kind,
	output logic signed [mrve_pkg::ACC_W-1:0]           dot_sum,
	output logic signed [mrve_pkg::ELEM_BITS-1:0]       vector_out,
	output logic [mrve_pkg::COL_W-1:0]                  out_col
);

	localparam int EW = mrve_pkg::ELEM_BITS;
	localparam int SHR_W = mrve_pkg::PROD_W - mrve_pkg::FRAC_BITS;

	logic [EW-1:0] matrix_q [mrve_pkg::DEPTH];

	mrve_pkg::op_t               op_q;
	logic [mrve_pkg::ADDR_W-1:0] addr_q;
	logic [mrve_pkg::COL_W-1:0]  col_q;
	logic signed [EW-1:0]        val_q;
	logic signed [EW-1:0]        scale_q;
	logic signed [EW-1:0]        rdata_q;
	logic signed [mrve_pkg::PROD_W-1:0] prod_q;
	logic signed [mrve_pkg::ACC_W-1:0]  acc_q;

	logic signed [EW-1:0]        mul_a, mul_b;
	logic signed [SHR_W-1:0]     prod_shr;
	logic signed [EW-1:0]        elem_base;
	logic signed [SHR_W:0]       elem_sum;
	logic signed [EW-1:0]        elem_sat;
	logic signed [mrve_pkg::ACC_W-1:0] acc_base;
	logic signed [mrve_pkg::ACC_W:0]   acc_sum;
	logic signed [mrve_pkg::ACC_W-1:0] acc_sat;
	logic                        mem_we;
	logic [EW-1:0]               mem_wdata;
	logic                        emit;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= mrve_pkg::op_t'(operation);
			addr_q  <= {row_index, col_index};
			col_q   <= col_index;
			val_q   <= element_value;
			scale_q <= scale;
		end
	end

	// Matrix memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			matrix_q[addr_q] <= mem_wdata;
		if (cmd.rd_en)
			rdata_q <= matrix_q[addr_q];
	end

	// Multiplier operand select and product register
	assign mul_a = (op_q == mrve_pkg::OP_ADD_TO_ROW) ? val_q : rdata_q;
	assign mul_b = (op_q == mrve_pkg::OP_DOT) ? val_q : scale_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= mrve_pkg::PROD_W'(mul_a) * mrve_pkg::PROD_W'(mul_b);
	end

	// Element update: base + (product >>> 12), saturated
	assign prod_shr  = prod_q[mrve_pkg::PROD_W-1:mrve_pkg::FRAC_BITS];
	assign elem_base = (op_q == mrve_pkg::OP_ADD_TO_ROW) ? rdata_q : val_q;
	assign elem_sum  = {{(SHR_W + 1 - EW){elem_base[EW-1]}}, elem_base}
		+ {prod_shr[SHR_W-1], prod_shr};

	always_comb begin
		if (elem_sum[SHR_W:EW-1] == '0 || elem_sum[SHR_W:EW-1] == '1)
			elem_sat = elem_sum[EW-1:0];
		else if (elem_sum[SHR_W])
			elem_sat = {1'b1, {(EW-1){1'b0}}};
		else
			elem_sat = {1'b0, {(EW-1){1'b1}}};
	end

	// Dot accumulation, cleared at column zero, saturated to 40 bits
	assign acc_base = (col_q == '0) ? '0 : acc_q;
	assign acc_sum  = {acc_base[mrve_pkg::ACC_W-1], acc_base}
		+ {{(mrve_pkg::ACC_W + 1 - mrve_pkg::PROD_W){prod_q[mrve_pkg::PROD_W-1]}}, prod_q};

	always_comb begin
		if (acc_sum[mrve_pkg::ACC_W] == acc_sum[mrve_pkg::ACC_W-1])
			acc_sat = acc_sum[mrve_pkg::ACC_W-1:0];
		else if (acc_sum[mrve_pkg::ACC_W])
			acc_sat = {1'b1, {(mrve_pkg::ACC_W-1){1'b0}}};
		else
			acc_sat = {1'b0, {(mrve_pkg::ACC_W-1){1'b1}}};
	end

	// Write-back and result decode
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = val_q;
		emit      = 1'b0;
		case (op_q)
			mrve_pkg::OP_WRITE: mem_we = cmd.finish;
			mrve_pkg::OP_DOT:   emit = cmd.finish && cmd.last;
			mrve_pkg::OP_ADD_TO_ROW: begin
				mem_we    = cmd.finish;
				mem_wdata = elem_sat;
			end
			mrve_pkg::OP_ADD_TO_VEC: emit = cmd.finish;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.finish && op_q == mrve_pkg::OP_DOT)
				acc_q <= acc_sat;
			result_valid <= emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_col <= col_q;
			if (op_q == mrve_pkg::OP_DOT) begin
				result_kind <= mrve_pkg::KIND_DOT;
				dot_sum     <= acc_sat;
				vector_out  <= '0;
			end else begin
				result_kind <= mrve_pkg::KIND_VEC;
				dot_sum     <= '0;
				vector_out  <= elem_sat;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/matrix_row_vector_engine_core.sv @@
// Top level of the matrix row/vector engine: controller plus datapath.
// Depends on mrve_pkg, mrve_ctrl and mrve_dp.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  A request (operation, row_index, col_index, element_value, scale) is taken
//  at a rising edge with start high and busy low. Each request addresses one
//  matrix element; row operations are issued one column at a time.
//  Operations: write element, dot step, add scaled vector to row, return
//  vector element plus scaled row element. Requests outside the rows and
//  columns in use are dropped and leave busy low.
//  Timing: a request passes through capture, memory read, multiply and
//  write-back, set by the registered matrix read and the one registered
//  multiplier; a new request is taken only once the last has finished.
//  A result, if any, shows on the result ports with result_valid high for
//  exactly one cycle, registered from the write-back step; it must be taken
//  then, the receiver cannot stall it.
//  Configuration: cfg_valid/cfg_ready with cfg_index (0 rows_in_use,
//  1 cols_in_use) and cfg_data; write only while the block is idle.
//  Reset: arst_n clears the sequencer, accumulator and result strobe and sets
//  rows_in_use 256, cols_in_use 128. The matrix memory is not cleared; its
//  entries must be written before they are read.
module matrix_row_vector_engine_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire [1:0]                             operation,
	input  wire [mrve_pkg::ROW_W-1:0]             row_index,
	input  wire [mrve_pkg::COL_W-1:0]             col_index,
	input  wire signed [mrve_pkg::ELEM_BITS-1:0]  element_value,
	input  wire signed [mrve_pkg::ELEM_BITS-1:0]  scale,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [mrve_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [mrve_pkg::ROWS_CFG_W-1:0]        cfg_data,
	output logic                                  result_valid,
	output logic                                  result_kind,
	output logic signed [mrve_pkg::ACC_W-1:0]     dot_sum,
	output logic signed [mrve_pkg::ELEM_BITS-1:0] vector_out,
	output logic [mrve_pkg::COL_W-1:0]            out_col
);

	mrve_pkg::cmd_t cmd;

	// Sequencer and configuration
	mrve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.row_index (row_index),
		.col_index (col_index),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.cmd       (cmd)
	);

	// Memory and arithmetic
	mrve_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.scale         (scale),
		.result_valid  (result_valid),
		.result_kind   (result_kind),
		.dot_sum       (dot_sum),
		.vector_out    (vector_out),
		.out_col       (out_col)
	);

endmodule
`default_nettype wire
